// File: rtl/core/tch_pkg.sv
// Shared types and codes for the tournament chooser.
package tch_pkg;

  // Fixed field widths of a transaction
  localparam int unsigned PcW  = 32;
  localparam int unsigned TagW = 6;

  // Number of distinct tag values a transaction can carry
  localparam int unsigned TagCount = 1 << TagW;

  typedef enum logic {
    OpPredict = 1'b0,
    OpUpdate  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrDupTag  = 2'd1,
    ErrNoEntry = 2'd2
  } err_e;

endpackage

// File: rtl/core/tch_if.sv
// Request and result channel interfaces of the tournament chooser.
interface tch_in_if;
  logic                     valid;
  logic                     ready;
  tch_pkg::op_e             op;
  logic [tch_pkg::PcW-1:0]  pc;
  logic [tch_pkg::TagW-1:0] tag;
  logic                     yp_pred;
  logic                     pct_pred;
  logic                     taken;

  modport source (output valid, op, pc, tag, yp_pred, pct_pred, taken, input ready);
  modport sink   (input valid, op, pc, tag, yp_pred, pct_pred, taken, output ready);
endinterface

interface tch_out_if;
  logic          valid;
  logic          ready;
  logic          prediction;
  logic          chose_second;
  logic          saved_yp;
  logic          saved_pct;
  tch_pkg::err_e error;

  modport source (output valid, prediction, chose_second, saved_yp, saved_pct, error,
                  input ready);
  modport sink   (input valid, prediction, chose_second, saved_yp, saved_pct, error,
                  output ready);
endinterface

// File: rtl/core/tch_ctr_table.sv
// Selector counter memory with clearing pass after reset and write bypass.
module tch_ctr_table #(
  parameter int unsigned INDEX_BITS = 10,
  parameter int unsigned CTR_WIDTH  = 4,
  parameter logic [CTR_WIDTH-1:0] INIT_VALUE = 4'd8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [INDEX_BITS-1:0] rd_idx_i,
  input  logic                  wr_en_i,
  input  logic [INDEX_BITS-1:0] wr_idx_i,
  input  logic [CTR_WIDTH-1:0]  wr_data_i,
  output logic [CTR_WIDTH-1:0]  rd_data_o,
  output logic                  busy_o
);

  localparam int unsigned Depth = 1 << INDEX_BITS;

  logic [CTR_WIDTH-1:0] mem [Depth];

  logic                  busy_q;
  logic [INDEX_BITS-1:0] clr_idx_q;
  logic [CTR_WIDTH-1:0]  rd_data_q;
  logic [INDEX_BITS-1:0] rd_idx_q;
  logic                  byp_valid_q;
  logic [INDEX_BITS-1:0] byp_idx_q;
  logic [CTR_WIDTH-1:0]  byp_data_q;

  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_widx;
  logic [CTR_WIDTH-1:0]  mem_wdata;

  // Select between the clearing sweep and normal writes
  always_comb begin
    mem_we    = busy_q || wr_en_i;
    mem_widx  = busy_q ? clr_idx_q : wr_idx_i;
    mem_wdata = busy_q ? INIT_VALUE : wr_data_i;
  end

  // Sweep every entry to the start value once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_idx_q <= '0;
    end else if (busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == {INDEX_BITS{1'b1}}) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Hold the last counter write so a read issued in the same cycle sees it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
    end else if (wr_en_i && !busy_q) begin
      byp_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !busy_q) begin
      byp_idx_q  <= wr_idx_i;
      byp_data_q <= wr_data_i;
    end
  end

  // Memory write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wdata;
    end
  end

  // Memory read port with registered data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
      rd_idx_q  <= rd_idx_i;
    end
  end

  assign rd_data_o = (byp_valid_q && (byp_idx_q == rd_idx_q)) ? byp_data_q : rd_data_q;
  assign busy_o    = busy_q;

endmodule

// File: rtl/core/tournament_chooser.sv
// Top level of the tournament chooser: selector counters and pending prediction store.
//
// Accepts one predict or update transaction per cycle unless the result side
// stalls or the counter memory is being cleared, and returns exactly one result
// transaction for each once the result side is ready: the counter memory and the
// pending prediction memory are read into the input stage, then the result is
// computed into the output register while the counter and the pending entry are
// written back. Writes from the item leaving the input stage are bypassed to the
// item entering it, so back-to-back transactions on the same counter or tag see
// current state. After reset the block clears the counter memory, one entry per
// cycle, and holds ready low until every entry has been cleared.
module tournament_chooser #(
  parameter int unsigned INDEX_BITS   = 10,
  parameter int unsigned CTR_WIDTH    = 4,
  parameter int unsigned INIT_STATE   = 2,
  parameter int unsigned PENDING_TAGS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tch_in_if.sink         in_i,
  tch_out_if.source      out_o
);

  localparam int unsigned SlotW   = $clog2(PENDING_TAGS);
  localparam int unsigned CtrHalf = 1 << (CTR_WIDTH - 1);
  localparam int unsigned CtrMaxI = (1 << CTR_WIDTH) - 1;
  localparam logic [CTR_WIDTH-1:0] InitValue = CTR_WIDTH'(
      (INIT_STATE == 0) ? 0 :
      (INIT_STATE == 1) ? CtrHalf - 1 :
      (INIT_STATE == 3) ? CtrMaxI : CtrHalf);
  localparam logic [CTR_WIDTH-1:0] CtrMax = {CTR_WIDTH{1'b1}};

  // Map a tag onto its pending slot (tag modulo the store depth)
  function automatic logic [SlotW-1:0] slot_of(input logic [tch_pkg::TagW-1:0] t);
    logic [SlotW-1:0] r;
    r = '0;
    for (int i = 0; i < tch_pkg::TagCount; i++) begin
      if (t == tch_pkg::TagW'(i)) begin
        r = SlotW'(i % PENDING_TAGS);
      end
    end
    return r;
  endfunction

  logic in_acc;
  logic s1_adv;
  logic tbl_busy;

  logic [INDEX_BITS-1:0] in_idx;
  logic [SlotW-1:0]      in_slot;

  // Input stage
  logic                  s1_valid_q;
  tch_pkg::op_e          s1_op_q;
  logic [INDEX_BITS-1:0] s1_idx_q;
  logic [SlotW-1:0]      s1_slot_q;
  logic                  s1_yp_q;
  logic                  s1_pct_q;
  logic                  s1_taken_q;

  // Pending store
  logic [PENDING_TAGS-1:0] pend_valid_q;
  logic [1:0]              pend_mem [PENDING_TAGS];
  logic [1:0]              pend_rd_q;
  logic                    pend_byp_valid_q;
  logic [SlotW-1:0]        pend_byp_slot_q;
  logic [1:0]              pend_byp_data_q;

  // Output register
  logic          out_valid_q;
  logic          out_pred_q;
  logic          out_second_q;
  logic          out_syp_q;
  logic          out_spct_q;
  tch_pkg::err_e out_err_q;

  // Result stage logic
  logic [CTR_WIDTH-1:0] ctr;
  logic [CTR_WIDTH-1:0] ctr_d;
  logic                 ctr_we;
  logic                 slot_hit;
  logic [1:0]           preds;
  logic                 pend_set;
  logic                 pend_clr;
  logic                 res_pred;
  logic                 res_second;
  logic                 res_syp;
  logic                 res_spct;
  tch_pkg::err_e        res_err;

  assign in_idx  = in_i.pc[INDEX_BITS+1:2];
  assign in_slot = slot_of(in_i.tag);

  // Advance the input stage whenever the output register is free or being taken
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !tbl_busy && (!s1_valid_q || s1_adv);
  assign in_acc     = in_i.valid && in_i.ready;

  tch_ctr_table #(
    .INDEX_BITS (INDEX_BITS),
    .CTR_WIDTH  (CTR_WIDTH),
    .INIT_VALUE (InitValue)
  ) u_ctr_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_idx_i  (in_idx),
    .wr_en_i   (ctr_we),
    .wr_idx_i  (s1_idx_q),
    .wr_data_i (ctr_d),
    .rd_data_o (ctr),
    .busy_o    (tbl_busy)
  );

  // Compute the result and the state changes of the item in the input stage
  always_comb begin
    slot_hit   = pend_valid_q[s1_slot_q];
    preds      = (pend_byp_valid_q && (pend_byp_slot_q == s1_slot_q)) ?
                 pend_byp_data_q : pend_rd_q;
    ctr_d      = ctr;
    ctr_we     = 1'b0;
    pend_set   = 1'b0;
    pend_clr   = 1'b0;
    res_pred   = 1'b0;
    res_second = 1'b0;
    res_syp    = 1'b0;
    res_spct   = 1'b0;
    res_err    = tch_pkg::ErrNone;
    unique case (s1_op_q)
      tch_pkg::OpPredict: begin
        res_second = ctr[CTR_WIDTH-1];
        res_pred   = res_second ? s1_pct_q : s1_yp_q;
        if (slot_hit) begin
          res_err = tch_pkg::ErrDupTag;
        end else begin
          pend_set = s1_adv;
        end
      end
      tch_pkg::OpUpdate: begin
        if (!slot_hit) begin
          res_err = tch_pkg::ErrNoEntry;
        end else begin
          pend_clr = s1_adv;
          res_syp  = preds[0];
          res_spct = preds[1];
          // Step toward the component that was right, only on disagreement
          if (preds[0] != preds[1]) begin
            ctr_we = s1_adv;
            if (preds[0] == s1_taken_q) begin
              ctr_d = (ctr == '0) ? ctr : ctr - 1'b1;
            end else begin
              ctr_d = (ctr == CtrMax) ? ctr : ctr + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q    <= in_i.op;
      s1_idx_q   <= in_idx;
      s1_slot_q  <= in_slot;
      s1_yp_q    <= in_i.yp_pred;
      s1_pct_q   <= in_i.pct_pred;
      s1_taken_q <= in_i.taken;
    end
  end

  // Pending valid bits and bypass control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q     <= '0;
      pend_byp_valid_q <= 1'b0;
    end else begin
      if (pend_set) begin
        pend_valid_q[s1_slot_q] <= 1'b1;
        pend_byp_valid_q        <= 1'b1;
      end else if (pend_clr) begin
        pend_valid_q[s1_slot_q] <= 1'b0;
      end
    end
  end

  // Hold the last stash write for a read issued in the same cycle
  always_ff @(posedge clk_i) begin
    if (pend_set) begin
      pend_byp_slot_q <= s1_slot_q;
      pend_byp_data_q <= {s1_pct_q, s1_yp_q};
    end
  end

  // Pending prediction memory write port
  always_ff @(posedge clk_i) begin
    if (pend_set) begin
      pend_mem[s1_slot_q] <= {s1_pct_q, s1_yp_q};
    end
  end

  // Pending prediction memory read port
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_rd_q <= pend_mem[in_slot];
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pred_q   <= res_pred;
      out_second_q <= res_second;
      out_syp_q    <= res_syp;
      out_spct_q   <= res_spct;
      out_err_q    <= res_err;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.prediction   = out_pred_q;
  assign out_o.chose_second = out_second_q;
  assign out_o.saved_yp     = out_syp_q;
  assign out_o.saved_pct    = out_spct_q;
  assign out_o.error        = out_err_q;

  // No transaction is taken while the counter memory is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni) tbl_busy |-> !in_i.ready)
    else $error("transaction accepted during counter clearing");

  // An item leaving the input stage always lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) s1_adv |=> out_valid_q)
    else $error("result lost between input stage and output register");

  // A counter write only comes from a matched update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      ctr_we |-> (s1_op_q == tch_pkg::OpUpdate) && slot_hit && s1_adv)
    else $error("counter written outside a matched update");

  // An unmatched update reports nothing but the error code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && (out_err_q == tch_pkg::ErrNoEntry)
      |-> !out_pred_q && !out_second_q && !out_syp_q && !out_spct_q)
    else $error("unmatched update carries result fields");

endmodule

// File: sim/tch_choice_checker.sv
// Checker for the tournament chooser: selector model, expected results and comparison.
module tch_choice_checker #(
  parameter int unsigned INDEX_BITS   = 10,
  parameter int unsigned CTR_WIDTH    = 4,
  parameter int unsigned INIT_STATE   = 2,
  parameter int unsigned PENDING_TAGS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tch_in_if           req_i,
  tch_out_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned open_results_o,
  output int unsigned results_checked_o
);

  localparam int unsigned TableSize = 1 << INDEX_BITS;
  localparam int unsigned CtrMax    = (1 << CTR_WIDTH) - 1;
  localparam int unsigned CtrHalf   = 1 << (CTR_WIDTH - 1);

  typedef struct packed {
    logic          prediction;
    logic          chose_second;
    logic          saved_yp;
    logic          saved_pct;
    tch_pkg::err_e error;
  } choice_t;

  // Private copy of the selector state
  logic [CTR_WIDTH-1:0] selector_ctr [TableSize];
  bit                   slot_busy    [PENDING_TAGS];
  logic [1:0]           slot_preds   [PENDING_TAGS];

  choice_t expected_choices [$];
  choice_t want;

  // Counter value after reset for each initial state setting
  function automatic logic [CTR_WIDTH-1:0] start_value();
    case (INIT_STATE)
      0:       return '0;
      1:       return CTR_WIDTH'(CtrHalf - 1);
      3:       return CTR_WIDTH'(CtrMax);
      default: return CTR_WIDTH'(CtrHalf);
    endcase
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < TableSize; i++) selector_ctr[i] = start_value();
    for (int i = 0; i < PENDING_TAGS; i++) begin
      slot_busy[i]  = 1'b0;
      slot_preds[i] = 2'b00;
    end
  endfunction

  // Work out the result of one transaction and advance the model state
  function automatic choice_t advance_choice(input tch_pkg::op_e op,
                                             input logic [tch_pkg::PcW-1:0] pc,
                                             input logic [tch_pkg::TagW-1:0] tag,
                                             input logic yp, input logic pct,
                                             input logic taken);
    int unsigned          idx;
    int unsigned          slot;
    logic [CTR_WIDTH-1:0] ctr;
    logic                 syp;
    logic                 spct;
    choice_t              res;
    idx  = 32'(pc[INDEX_BITS+1:2]);
    slot = tag % PENDING_TAGS;
    ctr  = selector_ctr[idx];
    res  = '0;
    if (op == tch_pkg::OpPredict) begin
      res.chose_second = ctr[CTR_WIDTH-1];
      res.prediction   = res.chose_second ? pct : yp;
      if (slot_busy[slot]) begin
        res.error = tch_pkg::ErrDupTag;
      end else begin
        slot_busy[slot]  = 1'b1;
        slot_preds[slot] = {pct, yp};
      end
    end else if (!slot_busy[slot]) begin
      res.error = tch_pkg::ErrNoEntry;
    end else begin
      syp             = slot_preds[slot][0];
      spct            = slot_preds[slot][1];
      slot_busy[slot] = 1'b0;
      // Step toward the component that was right, only on disagreement
      if (syp != spct) begin
        if (syp == taken) begin
          if (ctr != 0) ctr--;
        end else begin
          if (ctr != CtrMax) ctr++;
        end
        selector_ctr[idx] = ctr;
      end
      res.saved_yp  = syp;
      res.saved_pct = spct;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [1:0] want_v,
                                 input logic [1:0] got_v);
    $display("[checker] result %0d: %s expected %0d, got %0d",
             results_checked_o, field, want_v, got_v);
    fail_count_o++;
  endtask

  // Compare each result with the oldest expectation, then queue the new one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      expected_choices.delete();
      fail_count_o      = 0;
      open_results_o    = 0;
      results_checked_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        results_checked_o++;
        if (expected_choices.size() == 0) begin
          report_mismatch("unexpected result", 2'd0, 2'd1);
        end else begin
          want = expected_choices.pop_front();
          open_results_o--;
          if (rsp_i.prediction !== want.prediction)
            report_mismatch("prediction", 2'(want.prediction), 2'(rsp_i.prediction));
          if (rsp_i.chose_second !== want.chose_second)
            report_mismatch("chose_second", 2'(want.chose_second),
                            2'(rsp_i.chose_second));
          if (rsp_i.saved_yp !== want.saved_yp)
            report_mismatch("saved_yp", 2'(want.saved_yp), 2'(rsp_i.saved_yp));
          if (rsp_i.saved_pct !== want.saved_pct)
            report_mismatch("saved_pct", 2'(want.saved_pct), 2'(rsp_i.saved_pct));
          if (rsp_i.error !== want.error)
            report_mismatch("error", want.error, rsp_i.error);
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_choices.push_back(advance_choice(req_i.op, req_i.pc, req_i.tag,
                                                  req_i.yp_pred, req_i.pct_pred,
                                                  req_i.taken));
        open_results_o++;
      end
    end
  end

endmodule

// File: sim/tournament_chooser_test.sv
// Testbench top for the tournament chooser: clock, reset, stimulus and verdict.
module tournament_chooser_test;

  localparam int unsigned IndexBits   = 10;
  localparam int unsigned CounterBits = 4;
  localparam int unsigned InitState   = 2;
  localparam int unsigned PendingTags = 64;
  localparam int unsigned RandomItems = 1200;
  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxOpen     = 40;

  logic clk_i;
  logic rst_ni;

  tch_in_if  req_if ();
  tch_out_if rsp_if ();

  int unsigned fail_count;
  int unsigned open_results;
  int unsigned results_checked;
  int unsigned cycle_count;

  // Stimulus-side view of which tags are in flight
  bit                      tag_open [PendingTags];
  logic [tch_pkg::PcW-1:0] tag_pc   [PendingTags];
  logic                    tag_yp   [PendingTags];
  logic                    tag_pct  [PendingTags];
  int unsigned             n_open;
  int unsigned             n_predict;
  int unsigned             n_update;
  int unsigned             n_dup;
  int unsigned             n_orphan;
  bit                      steady;
  bit                      favour_second;

  tournament_chooser #(
    .INDEX_BITS  (IndexBits),
    .CTR_WIDTH   (CounterBits),
    .INIT_STATE  (InitState),
    .PENDING_TAGS(PendingTags)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  tch_choice_checker #(
    .INDEX_BITS  (IndexBits),
    .CTR_WIDTH   (CounterBits),
    .INIT_STATE  (InitState),
    .PENDING_TAGS(PendingTags)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .fail_count_o     (fail_count),
    .open_results_o   (open_results),
    .results_checked_o(results_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stall the result side at random, except in the steady stretch
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= steady || ($urandom_range(0, 99) >= 29);
    end
  end

  // Abandon the run at the cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[test] timeout after %0d cycles", cycle_count);
    $display("tournament_chooser: mismatch");
    $finish;
  end

  // Drive one transaction, after a random gap outside the steady stretch, and hold it until accepted
  task automatic send_item(input tch_pkg::op_e op, input logic [tch_pkg::PcW-1:0] pc,
                           input logic [tch_pkg::TagW-1:0] tag, input logic yp,
                           input logic pct, input logic taken);
    bit          ok;
    int unsigned slot;
    if (!steady) begin
      while ($urandom_range(0, 99) < 29) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid    <= 1'b1;
    req_if.op       <= op;
    req_if.pc       <= pc;
    req_if.tag      <= tag;
    req_if.yp_pred  <= yp;
    req_if.pct_pred <= pct;
    req_if.taken    <= taken;
    ok = 1'b0;
    while (!ok) begin
      @(negedge clk_i);
      ok = (req_if.ready === 1'b1);
      @(posedge clk_i);
    end
    // Track the in-flight tags as the block will see them
    slot = tag % PendingTags;
    if (op == tch_pkg::OpPredict) begin
      n_predict++;
      if (tag_open[slot]) begin
        n_dup++;
      end else begin
        tag_open[slot] = 1'b1;
        tag_pc[slot]   = pc;
        tag_yp[slot]   = yp;
        tag_pct[slot]  = pct;
        n_open++;
      end
    end else begin
      n_update++;
      if (!tag_open[slot]) begin
        n_orphan++;
      end else begin
        tag_open[slot] = 1'b0;
        n_open--;
      end
    end
  endtask

  // Find a slot that is in flight (or free), starting at a random place
  function automatic int pick_slot(input bit want_open);
    int start;
    int slot;
    start = $urandom_range(0, PendingTags - 1);
    for (int i = 0; i < PendingTags; i++) begin
      slot = (start + i) % PendingTags;
      if (tag_open[slot] == want_open) return slot;
    end
    return -1;
  endfunction

  // Random address whose table index mostly comes from a small pool, so counters saturate
  function automatic logic [tch_pkg::PcW-1:0] pool_pc();
    logic [tch_pkg::PcW-1:0] pc;
    logic [31:0]             idx;
    case ($urandom_range(0, 5))
      0:       idx = 0;
      1:       idx = (1 << IndexBits) - 1;
      2:       idx = 3;
      3:       idx = 77;
      4:       idx = 1 << (IndexBits - 1);
      default: idx = $urandom;
    endcase
    pc = $urandom;
    pc[IndexBits+1:2] = idx[IndexBits-1:0];
    return pc;
  endfunction

  initial begin
    int                      r;
    int                      slot;
    logic [tch_pkg::TagW-1:0] tag_v;
    logic                    yp_v;
    logic                    pct_v;
    logic                    taken_v;
    tch_pkg::op_e            op_v;

    steady        = 1'b0;
    favour_second = 1'b0;
    n_open        = 0;
    n_predict     = 0;
    n_update      = 0;
    n_dup         = 0;
    n_orphan      = 0;
    for (int i = 0; i < PendingTags; i++) tag_open[i] = 1'b0;

    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.op       = tch_pkg::OpPredict;
    req_if.pc       = '0;
    req_if.tag      = '0;
    req_if.yp_pred  = 1'b0;
    req_if.pct_pred = 1'b0;
    req_if.taken    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, every pairing, duplicates, orphans, agreement
    send_item(tch_pkg::OpUpdate,  32'h0000_0000, 6'd5,  1'b1, 1'b1, 1'b1);
    send_item(tch_pkg::OpPredict, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 1'b1);
    send_item(tch_pkg::OpPredict, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, 1'b0);
    send_item(tch_pkg::OpPredict, 32'h0000_0004, 6'd1,  1'b1, 1'b0, 1'b0);
    send_item(tch_pkg::OpPredict, 32'h0000_0008, 6'd2,  1'b0, 1'b1, 1'b1);
    send_item(tch_pkg::OpPredict, 32'h0000_0FFC, 6'd3,  1'b0, 1'b1, 1'b0);
    send_item(tch_pkg::OpPredict, 32'hFFFF_F003, 6'd4,  1'b1, 1'b0, 1'b1);
    send_item(tch_pkg::OpPredict, 32'h0000_0000, 6'd0,  1'b1, 1'b1, 1'b0);
    send_item(tch_pkg::OpUpdate,  32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b1);
    send_item(tch_pkg::OpUpdate,  32'hFFFF_FFFF, 6'd63, 1'b0, 1'b1, 1'b0);
    send_item(tch_pkg::OpUpdate,  32'h0000_0004, 6'd1,  1'b0, 1'b0, 1'b1);
    send_item(tch_pkg::OpUpdate,  32'h0000_0008, 6'd2,  1'b1, 1'b1, 1'b0);
    send_item(tch_pkg::OpUpdate,  32'h0000_0004, 6'd1,  1'b0, 1'b0, 1'b1);
    send_item(tch_pkg::OpUpdate,  32'h0000_0FFC, 6'd3,  1'b0, 1'b0, 1'b0);
    send_item(tch_pkg::OpUpdate,  32'hFFFF_F003, 6'd4,  1'b1, 1'b1, 1'b0);
    send_item(tch_pkg::OpPredict, 32'h0000_0FFC, 6'd20, 1'b0, 1'b1, 1'b1);
    send_item(tch_pkg::OpUpdate,  32'h0000_0FFC, 6'd20, 1'b1, 1'b0, 1'b1);
    send_item(tch_pkg::OpPredict, 32'h0000_0FFC, 6'd20, 1'b1, 1'b0, 1'b0);
    send_item(tch_pkg::OpUpdate,  32'h0000_0FFC, 6'd20, 1'b0, 1'b1, 1'b1);
    send_item(tch_pkg::OpPredict, 32'h0000_0FFC, 6'd21, 1'b0, 1'b1, 1'b0);

    // Random: mostly predict/update pairs, some duplicates, orphans and noise
    for (int i = 0; i < RandomItems; i++) begin
      steady = (i >= 500) && (i < 700);
      if (i % 150 == 0) favour_second = ~favour_second;
      r       = $urandom_range(0, 99);
      yp_v    = 1'($urandom_range(0, 1));
      pct_v   = 1'($urandom_range(0, 1));
      taken_v = 1'($urandom_range(0, 1));
      if (r < 3) begin
        op_v  = ($urandom_range(0, 1) != 0) ? tch_pkg::OpUpdate : tch_pkg::OpPredict;
        tag_v = tch_pkg::TagW'($urandom_range(0, tch_pkg::TagCount - 1));
        send_item(op_v, $urandom, tag_v, yp_v, pct_v, taken_v);
      end else if (r < 7) begin
        slot = pick_slot(1'b1);
        if (slot >= 0) begin
          tag_v = slot[tch_pkg::TagW-1:0];
          send_item(tch_pkg::OpPredict, pool_pc(), tag_v, yp_v, pct_v, taken_v);
        end
      end else if (r < 11) begin
        slot = pick_slot(1'b0);
        if (slot >= 0) begin
          tag_v = slot[tch_pkg::TagW-1:0];
          send_item(tch_pkg::OpUpdate, pool_pc(), tag_v, yp_v, pct_v, taken_v);
        end
      end else if (n_open == 0 || (n_open < MaxOpen && $urandom_range(0, 1))) begin
        slot  = pick_slot(1'b0);
        tag_v = slot[tch_pkg::TagW-1:0];
        send_item(tch_pkg::OpPredict, pool_pc(), tag_v, yp_v, pct_v, taken_v);
      end else begin
        slot  = pick_slot(1'b1);
        tag_v = slot[tch_pkg::TagW-1:0];
        // Lean the outcome toward one component so counters reach both rails
        if (tag_yp[slot] != tag_pct[slot] && $urandom_range(0, 99) < 80)
          taken_v = favour_second ? tag_pct[slot] : tag_yp[slot];
        send_item(tch_pkg::OpUpdate, tag_pc[slot], tag_v, yp_v, pct_v, taken_v);
      end
    end
    steady = 1'b0;
    req_if.valid <= 1'b0;

    // Drain outstanding results, then allow for the pipeline
    @(posedge clk_i);
    while (open_results != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("[test] sent %0d predict and %0d update transactions", n_predict, n_update);
    $display("[test] %0d duplicate tags, %0d updates with no entry, %0d results checked",
             n_dup, n_orphan, results_checked);
    if (fail_count == 0 && open_results == 0) begin
      $display("tournament_chooser: match");
    end else begin
      $display("tournament_chooser: mismatch");
    end
    $finish;
  end

endmodule
